>>> src/npt_pkg.sv
// Shared types and constants for the neighbor position table.
// Holds operation and status codes, the table entry layout and the control states.
// No dependencies.
package npt_pkg;

   localparam int NPT_ENTRIES = 16;

   localparam int KEY_W   = 64;
   localparam int STAMP_W = 48;
   localparam int COORD_W = 64;
   localparam int IFACE_W = 10;
   localparam int IFO_W   = 11;
   localparam int CNT_W   = 5;

   localparam logic [COORD_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
   localparam logic [IFO_W-1:0]   IFACE_MISS = '1;

   typedef enum logic [2:0] {
      FN_SET    = 3'd0,
      FN_LOOKUP = 3'd1,
      FN_REMOVE = 3'd2,
      FN_AGE    = 3'd3,
      FN_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2,
      STS_INVALID   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SM_IDLE,
      SM_SCAN,
      SM_FIN
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [IFACE_W-1:0] iface;
   } entry_type;

endpackage

>>> src/neighbor_position_table_with_aging_core.sv
// Neighbor position table: keyed store of positions with age-out.
// Depends on npt_pkg for codes, widths and the entry layout.
//
// Usage:
//   req channel: one beat carries one operation (set, lookup, remove, age out,
//   clear) selected by req_tuser; req_tdata carries key, stamp, coordinates
//   and interface id. rsp channel: exactly one beat per request, with the
//   status, lookup data, oldest stored stamp and the entry count.
//   Every operation walks all ENTRIES slots of the entry memory once, one
//   slot a cycle through its single read port; match search, free slot
//   search, age-out, oldest stamp and count all come out of that one walk.
//   Steps: SM_IDLE registers the request beat, SM_SCAN walks the slots and
//   SM_FIN writes the response register; new requests are taken only in SM_IDLE.
//   The response sits in an output register, so a new request is taken while
//   the previous response still waits; a request that finishes its walk while
//   the output register is occupied holds in its final step until rsp_tready.
//   Reset: synchronous, clears all valid bits (empty table) and the response
//   valid; entry memory contents are left as they are and never read unless
//   written.
module neighbor_position_table_with_aging_core
   import npt_pkg::*;
#(
   parameter int ENTRIES = NPT_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // key[63:0], stamp[111:64], coord_x[175:112], coord_y[239:176],
   // coord_z[303:240], iface_in[313:304], zero[319:314]
   input  logic [319:0] req_tdata,
   // func[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], found[2], pos_x[66:3], pos_y[130:67], pos_z[194:131],
   // iface_out[205:195], oldest_stamp[253:206], entry_count[258:254], zero[263:259]
   output logic [263:0] rsp_tdata
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] LAST = CW'(ENTRIES);

   // control
   state_type            state_ff, state_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // request and scan payload
   logic [2:0]           func_ff, func_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [COORD_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [IFACE_W-1:0]   iface_ff, iface_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 hit_ff, hit_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic                 free_ok_ff, free_ok_in;
   logic [AW-1:0]        free_ff, free_in;
   logic [COORD_W-1:0]   lk_x_ff, lk_x_in, lk_y_ff, lk_y_in, lk_z_ff, lk_z_in;
   logic [IFACE_W-1:0]   lk_iface_ff, lk_iface_in;
   logic [CW-1:0]        keep_cnt_ff, keep_cnt_in;
   logic [STAMP_W-1:0]   oldest_ff, oldest_in;

   // response payload
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [IFO_W-1:0]     rsp_iface_ff, rsp_iface_in;
   logic [STAMP_W-1:0]   rsp_oldest_ff, rsp_oldest_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;

   // entry memory
   entry_type            entry_mem [ENTRIES];
   entry_type            rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   entry_type            wr_data;

   logic                 req_beat;
   logic                 out_free;
   logic [AW-1:0]        p_idx;
   logic                 p_valid;
   logic                 p_hit;
   logic                 p_aged;
   logic                 p_keep;
   logic [AW-1:0]        tgt_slot;
   logic [CW+CNT_W-1:0]  count_ext;

   assign req_tready = (state_ff == SM_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rd_addr  = (cnt_ff < LAST) ? cnt_ff[AW-1:0] : '0;
   assign p_idx    = AW'(cnt_ff - CW'(1));
   assign p_valid  = valid_ff[p_idx];
   assign p_hit    = p_valid && (rd_data_ff.key == key_ff);
   assign p_aged   = p_valid && (rd_data_ff.stamp <= stamp_ff);
   assign tgt_slot = hit_ff ? slot_ff : free_ff;

   always_comb begin
      p_keep = p_valid;
      case (func_ff)
         FN_SET, FN_REMOVE: begin
            if (p_hit) p_keep = 1'b0;
         end
         FN_AGE: begin
            if (p_aged) p_keep = 1'b0;
         end
         FN_CLEAR: begin
            p_keep = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      stamp_in      = stamp_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      iface_in      = iface_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      free_ok_in    = free_ok_ff;
      free_in       = free_ff;
      lk_x_in       = lk_x_ff;
      lk_y_in       = lk_y_ff;
      lk_z_in       = lk_z_ff;
      lk_iface_in   = lk_iface_ff;
      keep_cnt_in   = keep_cnt_ff;
      oldest_in     = oldest_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_iface_in  = rsp_iface_ff;
      rsp_oldest_in = rsp_oldest_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = tgt_slot;
      wr_data       = '{key: key_ff, stamp: stamp_ff, x: x_ff, y: y_ff, z: z_ff,
                        iface: iface_ff};

      // drop the response once its beat is taken
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         SM_IDLE: begin
            if (req_beat) begin
               func_in     = req_tuser;
               key_in      = req_tdata[63:0];
               stamp_in    = req_tdata[111:64];
               x_in        = req_tdata[175:112];
               y_in        = req_tdata[239:176];
               z_in        = req_tdata[303:240];
               iface_in    = req_tdata[313:304];
               cnt_in      = '0;
               hit_in      = 1'b0;
               free_ok_in  = 1'b0;
               keep_cnt_in = '0;
               oldest_in   = '1;
               state_in    = SM_SCAN;
            end
         end
         SM_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            // read data for slot cnt-1 is on rd_data_ff
            if (cnt_ff != '0) begin
               if (p_hit) begin
                  hit_in      = 1'b1;
                  slot_in     = p_idx;
                  lk_x_in     = rd_data_ff.x;
                  lk_y_in     = rd_data_ff.y;
                  lk_z_in     = rd_data_ff.z;
                  lk_iface_in = rd_data_ff.iface;
               end
               if (!p_valid && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in    = p_idx;
               end
               if (func_ff == FN_AGE && p_aged) valid_in[p_idx] = 1'b0;
               if (p_keep) begin
                  keep_cnt_in = keep_cnt_ff + CW'(1);
                  if (rd_data_ff.stamp < oldest_ff) oldest_in = rd_data_ff.stamp;
               end
            end
            if (cnt_ff == LAST) state_in = SM_FIN;
         end
         SM_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_found_in  = 1'b0;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_z_in      = '0;
               rsp_iface_in  = '0;
               rsp_oldest_in = oldest_ff;
               rsp_count_in  = keep_cnt_ff;
               case (func_ff)
                  FN_SET: begin
                     if (key_ff == '0) begin
                        rsp_status_in = STS_INVALID;
                     end else if (!hit_ff && !free_ok_ff) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        wr_en              = 1'b1;
                        valid_in[tgt_slot] = 1'b1;
                        rsp_count_in       = keep_cnt_ff + CW'(1);
                        if (stamp_ff < oldest_ff) rsp_oldest_in = stamp_ff;
                     end
                  end
                  FN_LOOKUP: begin
                     if (hit_ff) begin
                        rsp_found_in = 1'b1;
                        rsp_x_in     = lk_x_ff;
                        rsp_y_in     = lk_y_ff;
                        rsp_z_in     = lk_z_ff;
                        rsp_iface_in = {1'b0, lk_iface_ff};
                     end else begin
                        rsp_status_in = STS_NOT_FOUND;
                        rsp_x_in      = QNAN_BITS;
                        rsp_y_in      = QNAN_BITS;
                        rsp_z_in      = QNAN_BITS;
                        rsp_iface_in  = IFACE_MISS;
                     end
                  end
                  FN_REMOVE: begin
                     if (hit_ff) valid_in[slot_ff] = 1'b0;
                     else rsp_status_in = STS_NOT_FOUND;
                  end
                  FN_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                  end
               endcase
               state_in = SM_IDLE;
            end
         end
         default: begin
            state_in = SM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SM_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      stamp_ff      <= stamp_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      iface_ff      <= iface_in;
      cnt_ff        <= cnt_in;
      hit_ff        <= hit_in;
      slot_ff       <= slot_in;
      free_ok_ff    <= free_ok_in;
      free_ff       <= free_in;
      lk_x_ff       <= lk_x_in;
      lk_y_ff       <= lk_y_in;
      lk_z_ff       <= lk_z_in;
      lk_iface_ff   <= lk_iface_in;
      keep_cnt_ff   <= keep_cnt_in;
      oldest_ff     <= oldest_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_iface_ff  <= rsp_iface_in;
      rsp_oldest_ff <= rsp_oldest_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign count_ext  = {{CNT_W{1'b0}}, rsp_count_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, count_ext[CNT_W-1:0], rsp_oldest_ff, rsp_iface_ff,
                        rsp_z_ff, rsp_y_ff, rsp_x_ff, rsp_found_ff, rsp_status_ff};

   // the walk never counts more live entries than there are slots
   a_keep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SM_FIN) |-> (keep_cnt_ff <= LAST))
      else $error("live entry count exceeds table size");

   // an empty table reports all ones as oldest stamp
   a_empty_oldest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_count_ff == '0) |-> (rsp_oldest_ff == '1))
      else $error("empty table with a stored oldest stamp");

   // a clear leaves no valid entry behind
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SM_FIN && out_free && func_ff == FN_CLEAR)
      |=> (valid_ff == '0 && rsp_count_ff == '0))
      else $error("clear left valid entries");

   // a lookup miss carries the miss interface id
   a_miss_iface: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STS_NOT_FOUND && !rsp_found_ff
       && rsp_x_ff == QNAN_BITS) |-> (rsp_iface_ff == IFACE_MISS))
      else $error("lookup miss without miss interface id");

endmodule

>>> tb/sv/tb_neighbor_position_table_with_aging_core.sv
// Self-checking testbench for the neighbor position table core.
// Drives set/lookup/remove/age/clear beats, predicts every response from its
// own table copy and compares field by field. Needs npt_pkg and the core.
`timescale 1ns / 1ps

module tb_neighbor_position_table_with_aging_core;
   import npt_pkg::*;

   localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FN_SPARE_LAST  = 3'd7;
   localparam int RANDOM_OPS  = 900;
   localparam int KEY_POOL    = 24;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [2:0]         func;
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [IFACE_W-1:0] iface;
   } table_op_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [COORD_W-1:0] pz;
      logic [IFO_W-1:0]   ifo;
      logic [STAMP_W-1:0] oldest;
      logic [CNT_W-1:0]   count;
   } table_reply_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_CYCLE
   } ready_style_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [319:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [263:0] rsp_tdata;

   // Predicted table contents
   logic               nbr_valid [NPT_ENTRIES] = '{default: 1'b0};
   logic [KEY_W-1:0]   nbr_key   [NPT_ENTRIES];
   logic [STAMP_W-1:0] nbr_stamp [NPT_ENTRIES];
   logic [COORD_W-1:0] nbr_x     [NPT_ENTRIES];
   logic [COORD_W-1:0] nbr_y     [NPT_ENTRIES];
   logic [COORD_W-1:0] nbr_z     [NPT_ENTRIES];
   logic [IFACE_W-1:0] nbr_iface [NPT_ENTRIES];

   table_op_type    ops_to_send [$];
   table_reply_type replies_due [$];
   table_op_type    cur_op = '0;
   logic            req_beat_taken = 1'b0;
   logic            hold_rsp = 1'b0;
   int              ops_accepted = 0;
   int              mismatch_count = 0;
   int              idle_left = 0;
   int              burst_left = 0;
   int              style_left = 0;
   int              style_phase = 0;
   ready_style_type ready_style = RDY_ALWAYS;

   neighbor_position_table_with_aging_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_op(logic [2:0] func, logic [KEY_W-1:0] key,
                                    logic [STAMP_W-1:0] stamp, logic [COORD_W-1:0] x,
                                    logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                    logic [IFACE_W-1:0] iface);
      table_op_type op;
      op = '{func: func, key: key, stamp: stamp, x: x, y: y, z: z, iface: iface};
      ops_to_send = {ops_to_send, op};
   endfunction

   // Apply one operation to the predicted table and return the reply it causes.
   function automatic table_reply_type table_apply(table_op_type op);
      table_reply_type r;
      int hit;
      int spare;
      int slot;
      int live;
      r = '0;
      r.status = STS_OK;
      r.oldest = '1;
      hit = -1;
      spare = -1;
      live = 0;
      for (int i = 0; i < NPT_ENTRIES; i++) begin
         if (nbr_valid[i] && nbr_key[i] == op.key && hit < 0) hit = i;
         if (!nbr_valid[i] && spare < 0) spare = i;
      end
      case (op.func)
         FN_SET: begin
            slot = (hit >= 0) ? hit : spare;
            if (op.key == '0) begin
               r.status = STS_INVALID;
            end else if (slot < 0) begin
               r.status = STS_FULL;
            end else begin
               nbr_valid[slot] = 1'b1;
               nbr_key[slot]   = op.key;
               nbr_stamp[slot] = op.stamp;
               nbr_x[slot]     = op.x;
               nbr_y[slot]     = op.y;
               nbr_z[slot]     = op.z;
               nbr_iface[slot] = op.iface;
            end
         end
         FN_LOOKUP: begin
            if (hit < 0) begin
               r.status = STS_NOT_FOUND;
               r.px  = QNAN_BITS;
               r.py  = QNAN_BITS;
               r.pz  = QNAN_BITS;
               r.ifo = IFACE_MISS;
            end else begin
               r.found = 1'b1;
               r.px  = nbr_x[hit];
               r.py  = nbr_y[hit];
               r.pz  = nbr_z[hit];
               r.ifo = {1'b0, nbr_iface[hit]};
            end
         end
         FN_REMOVE: begin
            if (hit < 0) r.status = STS_NOT_FOUND;
            else nbr_valid[hit] = 1'b0;
         end
         FN_AGE: begin
            for (int i = 0; i < NPT_ENTRIES; i++)
               if (nbr_valid[i] && nbr_stamp[i] <= op.stamp) nbr_valid[i] = 1'b0;
         end
         FN_CLEAR: begin
            for (int i = 0; i < NPT_ENTRIES; i++) nbr_valid[i] = 1'b0;
         end
         default: ;
      endcase
      for (int i = 0; i < NPT_ENTRIES; i++) begin
         if (nbr_valid[i]) begin
            live++;
            if (nbr_stamp[i] < r.oldest) r.oldest = nbr_stamp[i];
         end
      end
      r.count = live[CNT_W-1:0];
      return r;
   endfunction

   task automatic flag_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %h, want %h", name, got, want));
   endtask

   // Sender: bursts of beats with idle gaps; an offered beat holds until taken.
   always @(negedge clock) begin : drive_req
      logic offer;
      offer = req_tvalid && !req_beat_taken;
      if (!offer && !reset) begin
         if (idle_left > 0) begin
            idle_left--;
         end else if (ops_to_send.size() > 0) begin
            cur_op = ops_to_send.pop_front();
            offer = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
      req_tvalid <= offer;
      req_tuser  <= cur_op.func;
      req_tdata  <= {6'b0, cur_op.iface, cur_op.z, cur_op.y, cur_op.x,
                     cur_op.stamp, cur_op.key};
   end

   // Receiver: a stall pattern that changes style whenever style_left runs out.
   always @(negedge clock) begin : drive_rsp_ready
      logic rdy;
      if (style_left == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 3));
         style_left = $urandom_range(40, 300);
      end else begin
         style_left--;
      end
      style_phase++;
      case (ready_style)
         RDY_ALWAYS: rdy = 1'b1;
         RDY_COIN:   rdy = 1'($urandom_range(0, 1));
         RDY_SPARSE: rdy = ($urandom_range(0, 3) == 0);
         default:    rdy = (style_phase % 7) < 4;
      endcase
      rsp_tready <= rdy && !hold_rsp;
   end

   always @(posedge clock) begin : watch
      table_reply_type got;
      table_reply_type want;
      table_op_type    seen;
      req_beat_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         // Check the response first: it always belongs to an older request.
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.found  = rsp_tdata[2];
            got.px     = rsp_tdata[66:3];
            got.py     = rsp_tdata[130:67];
            got.pz     = rsp_tdata[194:131];
            got.ifo    = rsp_tdata[205:195];
            got.oldest = rsp_tdata[253:206];
            got.count  = rsp_tdata[258:254];
            if (replies_due.size() == 0) begin
               flag_mismatch("response beat with no request pending");
            end else begin
               want = replies_due.pop_front();
               check_field("status", got.status, want.status);
               check_field("found", got.found, want.found);
               check_field("pos_x", got.px, want.px);
               check_field("pos_y", got.py, want.py);
               check_field("pos_z", got.pz, want.pz);
               check_field("iface_out", got.ifo, want.ifo);
               check_field("oldest_stamp", got.oldest, want.oldest);
               check_field("entry_count", got.count, want.count);
            end
         end
         if (req_tvalid && req_tready) begin
            seen.func  = req_tuser;
            seen.key   = req_tdata[63:0];
            seen.stamp = req_tdata[111:64];
            seen.x     = req_tdata[175:112];
            seen.y     = req_tdata[239:176];
            seen.z     = req_tdata[303:240];
            seen.iface = req_tdata[313:304];
            replies_due = {replies_due, table_apply(seen)};
            ops_accepted++;
         end
      end
   end

   // Long receiver hold-off so the core fills its output stage and stalls input.
   initial begin
      wait (ops_accepted >= 200);
      @(negedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb_neighbor_position_table_with_aging_core: done, errors");
      $finish;
   end

   initial begin
      logic [KEY_W-1:0]   key_pool [KEY_POOL];
      logic [STAMP_W-1:0] now;
      logic [STAMP_W-1:0] cut;
      logic [KEY_W-1:0]   k;
      int                 pick;
      int                 counted;

      // Directed: edge values, every operation, each corner of the table.
      queue_op(FN_LOOKUP, '0, '0, '0, '0, '0, '0);
      queue_op(FN_SET, '0, 48'd7, rand64(), rand64(), rand64(), 10'd3);
      queue_op(FN_REMOVE, 64'h5A5A, '0, '0, '0, '0, '0);
      queue_op(FN_SET, '1, '1, '1, '1, '1, '1);
      queue_op(FN_SET, 64'd1, '0, '0, '0, '0, '0);
      queue_op(FN_LOOKUP, '1, '0, '0, '0, '0, '0);
      queue_op(FN_SET, 64'd1, 48'd5, rand64(), rand64(), rand64(), 10'h155);
      queue_op(FN_AGE, '0, 48'd5, '0, '0, '0, '0);
      for (int i = 0; i < NPT_ENTRIES - 1; i++)
         queue_op(FN_SET, 64'h100 + i, 48'd10 + i, rand64(), rand64(), rand64(),
                  IFACE_W'($urandom));
      queue_op(FN_SET, 64'h2000, 48'd40, rand64(), rand64(), rand64(), 10'd9);
      queue_op(FN_SPARE_LAST, 64'h104, '1, rand64(), rand64(), rand64(), '1);
      queue_op(FN_CLEAR, rand64(), '1, '0, '0, '0, '0);

      // Random: mostly sets and lookups over a small key pool so the table
      // fills, hits, overflows and ages; the rest is noise.
      for (int i = 0; i < KEY_POOL; i++) begin
         key_pool[i] = rand64();
         if (key_pool[i] == '0) key_pool[i] = 64'd1;
      end
      now = STAMP_W'($urandom_range(1000, 100000));
      counted = 0;
      while (counted < RANDOM_OPS) begin
         now += $urandom_range(0, 3);
         k = key_pool[$urandom_range(0, KEY_POOL - 1)];
         pick = $urandom_range(0, 99);
         counted++;
         if (pick < 40) begin
            queue_op(FN_SET, k, now, rand64(), rand64(), rand64(), IFACE_W'($urandom));
         end else if (pick < 47) begin
            queue_op(FN_SET, k, STAMP_W'(rand64()), rand64(), rand64(), rand64(),
                     IFACE_W'($urandom));
         end else if (pick < 50) begin
            queue_op(FN_SET, ($urandom_range(0, 1) ? '0 : rand64()), now, rand64(),
                     rand64(), rand64(), IFACE_W'($urandom));
         end else if (pick < 75) begin
            if ($urandom_range(0, 6) == 0) k = ($urandom_range(0, 1) ? '0 : rand64());
            queue_op(FN_LOOKUP, k, STAMP_W'(rand64()), rand64(), rand64(), rand64(),
                     IFACE_W'($urandom));
         end else if (pick < 87) begin
            if ($urandom_range(0, 9) == 0) k = rand64();
            queue_op(FN_REMOVE, k, STAMP_W'(rand64()), rand64(), rand64(), rand64(),
                     IFACE_W'($urandom));
         end else if (pick < 95) begin
            case ($urandom_range(0, 9))
               0:       cut = '0;
               1:       cut = '1;
               2:       cut = STAMP_W'(rand64());
               default: cut = now - $urandom_range(0, 60);
            endcase
            queue_op(FN_AGE, rand64(), cut, rand64(), rand64(), rand64(),
                     IFACE_W'($urandom));
         end else if (pick < 97) begin
            queue_op(FN_CLEAR, rand64(), STAMP_W'(rand64()), rand64(), rand64(), rand64(),
                     IFACE_W'($urandom));
         end else begin
            // Undefined codes are ignored by the core; do not count them.
            queue_op(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), k, now, rand64(),
                     rand64(), rand64(), IFACE_W'($urandom));
            counted--;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (ops_to_send.size() != 0 || req_tvalid || replies_due.size() != 0)
         @(posedge clock);
      repeat (NPT_ENTRIES + 8) @(posedge clock);
      if (replies_due.size() != 0) flag_mismatch("responses still outstanding at end");

      if (mismatch_count == 0) begin
         $display("tb_neighbor_position_table_with_aging_core: done, clean");
      end else begin
         $display("tb_neighbor_position_table_with_aging_core: done, errors");
      end
      $finish;
   end

endmodule
